### rtl/core/first_fit_chunk_allocator_top_macros.svh
// Assertion helpers for the chunk allocator.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ffca_pkg.sv
package ffca_pkg;

  localparam int MAX_CHUNKS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;
  localparam logic [31:0] POOL_RESET = 32'd16777216;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_MEM    = 2'd1;
  localparam status_t ST_TBL_FULL  = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

### rtl/core/first_fit_chunk_allocator_top.sv
// Channel | Direction | Handshake            | Payload
// in_     | slave     | in_tvalid/in_tready   | tuser: kind; tdata: req_size, align_log2,
//         |           |                       |        release_offset
// out_    | master    | out_tvalid/out_tready | tdata: status, offset
// cfg_    | slave     | cfg_valid/cfg_ready   | cfg_data: pool_size
// One request at a time. Allocate: the table is scanned for the first free chunk that
// fits, and on a split the entries above it move up by one to make room for the rest.
// Free: the table is scanned for the entry holding the offset, and entries move down
// by one for each merge. The chunk table memory is read and written in separate states.
// After reset or a pool_size write, the S_INIT state writes the initial chunk before
// requests are taken. A stalled result waits in the output register.
`include "first_fit_chunk_allocator_top_macros.svh"

module first_fit_chunk_allocator_top #(
  parameter int MAX_CHUNKS = ffca_pkg::MAX_CHUNKS_DEF,
  parameter int ADDR_BITS  = ffca_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // req_size[31:0], align_log2[36:32], release_offset[68:37]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], offset[33:2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // pool_size
);

  localparam int AW = ADDR_BITS;
  localparam int PW = (AW > 32) ? AW : 32;
  localparam int XW = PW + 2;
  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int EW = 2 * AW + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_A_RD   = 5'd2;
  localparam logic [4:0] S_A_AL   = 5'd3;
  localparam logic [4:0] S_A_FIT  = 5'd4;
  localparam logic [4:0] S_A_WR   = 5'd5;
  localparam logic [4:0] S_SU_RD  = 5'd6;
  localparam logic [4:0] S_SU_WR  = 5'd7;
  localparam logic [4:0] S_A_NEW  = 5'd8;
  localparam logic [4:0] S_F_RD   = 5'd9;
  localparam logic [4:0] S_F_EV   = 5'd10;
  localparam logic [4:0] S_FN_RD  = 5'd11;
  localparam logic [4:0] S_FN_EV  = 5'd12;
  localparam logic [4:0] S_RM_RD  = 5'd13;
  localparam logic [4:0] S_RM_WR  = 5'd14;
  localparam logic [4:0] S_FP_RD  = 5'd15;
  localparam logic [4:0] S_FP_EV  = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [EW-1:0] mem [MAX_CHUNKS];
  logic [EW-1:0] rd_q;
  logic          rd_en, we;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] h_r, h_nxt;
  logic [AW-1:0] pool_r, pool_nxt;
  logic [AW-1:0] hs_r, hs_nxt, hl_r, hl_nxt;
  logic          ret_prev_r, ret_prev_nxt;
  logic          endv_r, endv_nxt;
  logic [CW-1:0] endh_r, endh_nxt;
  logic [AW-1:0] ends_r, ends_nxt, endl_r, endl_nxt;
  logic [XW-1:0] size_r, size_nxt, off_r, off_nxt;
  logic [4:0]    lg_r, lg_nxt;
  logic [XW-1:0] aligned_r, aligned_nxt, total_r, total_nxt;
  logic [AW-1:0] s_r, s_nxt, rem_r, rem_nxt;
  ffca_pkg::status_t res_st_r, res_st_nxt;
  logic [31:0]   res_off_r, res_off_nxt;
  logic          out_valid_r;
  logic [39:0]   out_data_r;

  // fields of the entry just read
  logic [AW-1:0] q_start, q_len;
  logic          q_free;
  logic [XW-1:0] q_start_x, q_len_x, amask, total_x;
  logic [PW-1:0] cfg_ext;
  logic [AW-1:0] cfg_sat;

  assign q_start   = rd_q[AW-1:0];
  assign q_len     = rd_q[2*AW-1:AW];
  assign q_free    = rd_q[2*AW];
  assign q_start_x = XW'(q_start);
  assign q_len_x   = XW'(q_len);
  assign amask     = (XW'(1) << lg_r) - XW'(1);
  assign total_x   = aligned_r - q_start_x + size_r;
  assign cfg_ext   = PW'(cfg_data);
  assign cfg_sat   = (cfg_ext > PW'({AW{1'b1}})) ? {AW{1'b1}} : cfg_ext[AW-1:0];

  // a pool write takes precedence over a request in the same cycle
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    h_nxt        = h_r;
    pool_nxt     = pool_r;
    hs_nxt       = hs_r;
    hl_nxt       = hl_r;
    ret_prev_nxt = ret_prev_r;
    endv_nxt     = endv_r;
    endh_nxt     = endh_r;
    ends_nxt     = ends_r;
    endl_nxt     = endl_r;
    size_nxt     = size_r;
    off_nxt      = off_r;
    lg_nxt       = lg_r;
    aligned_nxt  = aligned_r;
    total_nxt    = total_r;
    s_nxt        = s_r;
    rem_nxt      = rem_r;
    res_st_nxt   = res_st_r;
    res_off_nxt  = res_off_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r[IW-1:0];
    we           = 1'b0;
    wr_addr      = idx_r[IW-1:0];
    wr_data      = rd_q;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          size_nxt    = XW'(in_tdata[31:0]);
          lg_nxt      = in_tdata[36:32];
          off_nxt     = XW'(in_tdata[68:37]);
          idx_nxt     = '0;
          endv_nxt    = 1'b0;
          res_st_nxt  = ffca_pkg::ST_OK;
          res_off_nxt = '0;
          state_nxt   = (in_tuser == ffca_pkg::KIND_FREE) ? S_F_RD : S_A_RD;
        end
      end
      S_INIT: begin
        we        = 1'b1;
        wr_addr   = '0;
        wr_data   = {1'b1, pool_r, {AW{1'b0}}};
        cnt_nxt   = CW'(1);
        state_nxt = S_IDLE;
      end
      S_A_RD: begin
        if (idx_r >= cnt_r) begin
          res_st_nxt = ffca_pkg::ST_NO_MEM;
          state_nxt  = S_OUT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_A_AL;
        end
      end
      S_A_AL: begin
        aligned_nxt = (q_start_x + amask) & ~amask;
        state_nxt   = S_A_FIT;
      end
      S_A_FIT: begin
        if (q_free && (total_x <= q_len_x)) begin
          total_nxt = total_x;
          s_nxt     = q_start;
          rem_nxt   = q_len - total_x[AW-1:0];
          if ((q_len != total_x[AW-1:0]) && (cnt_r == CW'(MAX_CHUNKS))) begin
            res_st_nxt = ffca_pkg::ST_TBL_FULL;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_A_WR;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_A_WR: begin
        we      = 1'b1;
        wr_data = {1'b0, total_r[AW-1:0], s_r};
        if (rem_r == '0) begin
          res_off_nxt = aligned_r[31:0];
          state_nxt   = S_OUT;
        end else begin
          k_nxt     = cnt_r;
          state_nxt = S_SU_RD;
        end
      end
      // move entries idx+1 .. cnt-1 up by one, top first
      S_SU_RD: begin
        if (k_r > idx_r + CW'(1)) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(k_r - CW'(1));
          state_nxt = S_SU_WR;
        end else begin
          state_nxt = S_A_NEW;
        end
      end
      S_SU_WR: begin
        we        = 1'b1;
        wr_addr   = k_r[IW-1:0];
        k_nxt     = k_r - CW'(1);
        state_nxt = S_SU_RD;
      end
      S_A_NEW: begin
        we          = 1'b1;
        wr_addr     = IW'(idx_r + CW'(1));
        wr_data     = {1'b1, rem_r, s_r + total_r[AW-1:0]};
        cnt_nxt     = cnt_r + CW'(1);
        res_off_nxt = aligned_r[31:0];
        state_nxt   = S_OUT;
      end
      S_F_RD: begin
        if (idx_r >= cnt_r) begin
          if (endv_r) begin
            h_nxt     = endh_r;
            hs_nxt    = ends_r;
            hl_nxt    = endl_r;
            state_nxt = S_FN_RD;
          end else begin
            res_st_nxt = ffca_pkg::ST_NOT_FOUND;
            state_nxt  = S_OUT;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_F_EV;
        end
      end
      S_F_EV: begin
        if (!q_free && (q_start_x <= off_r) && ((off_r - q_start_x) < q_len_x)) begin
          h_nxt     = idx_r;
          hs_nxt    = q_start;
          hl_nxt    = q_len;
          state_nxt = S_FN_RD;
        end else begin
          // fallback match on the end address, first one kept
          if (!q_free && !endv_r && ((q_start_x + q_len_x) == off_r)) begin
            endv_nxt = 1'b1;
            endh_nxt = idx_r;
            ends_nxt = q_start;
            endl_nxt = q_len;
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_F_RD;
        end
      end
      S_FN_RD: begin
        if (h_r + CW'(1) < cnt_r) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(h_r + CW'(1));
          state_nxt = S_FN_EV;
        end else begin
          state_nxt = S_FP_RD;
        end
      end
      S_FN_EV: begin
        if (q_free) begin
          hl_nxt       = hl_r + q_len;
          k_nxt        = h_r + CW'(1);
          ret_prev_nxt = 1'b0;
          state_nxt    = S_RM_RD;
        end else begin
          state_nxt = S_FP_RD;
        end
      end
      // drop entry k: move k+1 .. cnt-1 down by one
      S_RM_RD: begin
        if (k_r + CW'(1) < cnt_r) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(k_r + CW'(1));
          state_nxt = S_RM_WR;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ret_prev_r ? S_OUT : S_FP_RD;
        end
      end
      S_RM_WR: begin
        we        = 1'b1;
        wr_addr   = k_r[IW-1:0];
        k_nxt     = k_r + CW'(1);
        state_nxt = S_RM_RD;
      end
      S_FP_RD: begin
        if (h_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(h_r - CW'(1));
          state_nxt = S_FP_EV;
        end else begin
          we        = 1'b1;
          wr_addr   = h_r[IW-1:0];
          wr_data   = {1'b1, hl_r, hs_r};
          state_nxt = S_OUT;
        end
      end
      S_FP_EV: begin
        we = 1'b1;
        if (q_free) begin
          wr_addr      = IW'(h_r - CW'(1));
          wr_data      = {1'b1, q_len + hl_r, q_start};
          k_nxt        = h_r;
          ret_prev_nxt = 1'b1;
          state_nxt    = S_RM_RD;
        end else begin
          wr_addr   = h_r[IW-1:0];
          wr_data   = {1'b1, hl_r, hs_r};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      pool_nxt  = cfg_sat;
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CW'(1);
      pool_r      <= (PW'(ffca_pkg::POOL_RESET) > PW'({AW{1'b1}})) ? {AW{1'b1}}
                                                                     : AW'(ffca_pkg::POOL_RESET);
      out_valid_r <= 1'b0;
      endv_r      <= 1'b0;
      ret_prev_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pool_r     <= pool_nxt;
      endv_r     <= endv_nxt;
      ret_prev_r <= ret_prev_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    h_r       <= h_nxt;
    hs_r      <= hs_nxt;
    hl_r      <= hl_nxt;
    endh_r    <= endh_nxt;
    ends_r    <= ends_nxt;
    endl_r    <= endl_nxt;
    size_r    <= size_nxt;
    off_r     <= off_nxt;
    lg_r      <= lg_nxt;
    aligned_r <= aligned_nxt;
    total_r   <= total_nxt;
    s_r       <= s_nxt;
    rem_r     <= rem_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= {6'd0, res_off_r, res_st_r};
    end
  end

  `FFCA_ASSERT_IMP(a_cnt_range, 1'b1, (cnt_r != '0) && (cnt_r <= CW'(MAX_CHUNKS)), "chunk count out of range")
  `FFCA_ASSERT_IMP(a_split_room, state_r == S_A_NEW, cnt_r < CW'(MAX_CHUNKS), "split with full table")
  `FFCA_ASSERT_IMP(a_hit_valid, state_r == S_FN_RD, h_r < cnt_r, "freed entry beyond table")
  `FFCA_ASSERT_NXT(a_one_req, in_tvalid && in_tready && !cfg_valid, !in_tready, "second request taken while busy")

endmodule
